/* rtl/core/drdd_pkg.sv */
// Shared types and constants of the drum rotation direction detector.
package drdd_pkg;

  localparam int unsigned TimeWidthDefault = 32;
  localparam int unsigned TickWidth        = 32;
  localparam int unsigned CfgWidth         = 32;
  localparam int unsigned CfgIndexWidth    = 1;

  localparam logic [CfgWidth-1:0] CheckWindowReset = CfgWidth'(100);
  localparam logic [CfgWidth-1:0] StopTimeoutReset = CfgWidth'(15000);

  typedef enum logic [CfgIndexWidth-1:0] {
    RegCheckWindow = 1'b0,
    RegStopTimeout = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    FuncPulseA = 2'd0,
    FuncPulseB = 2'd1,
    FuncCheck  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    DirStopped = 2'd0,
    DirForward = 2'd1,
    DirReverse = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    AnnNone    = 2'd0,
    AnnForward = 2'd1,
    AnnReverse = 2'd2,
    AnnStopped = 2'd3
  } ann_e;

  // Result item, drum_state in the low bits.
  typedef struct packed {
    ann_e announce;
    dir_e drum_state;
  } drdd_res_t;

endpackage

/* rtl/core/drdd_eval.sv */
// Next-state and result logic for one sensor or check event.
module drdd_eval import drdd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  logic [1:0]            func_i,
  input  logic [TickWidth-1:0]  now_tick_i,
  input  logic [CfgWidth-1:0]   check_window_i,
  input  logic [CfgWidth-1:0]   stop_timeout_i,
  input  logic [TIME_WIDTH-1:0] last_pulse_time_i,
  input  logic [TIME_WIDTH-1:0] pulse_time_a_i,
  input  logic [TIME_WIDTH-1:0] pulse_time_b_i,
  input  logic [TIME_WIDTH-1:0] interval_a_to_b_i,
  input  logic [TIME_WIDTH-1:0] interval_b_to_a_i,
  input  dir_e                  direction_i,
  input  dir_e                  reported_direction_i,
  output logic [TIME_WIDTH-1:0] last_pulse_time_o,
  output logic [TIME_WIDTH-1:0] pulse_time_a_o,
  output logic [TIME_WIDTH-1:0] pulse_time_b_o,
  output logic [TIME_WIDTH-1:0] interval_a_to_b_o,
  output logic [TIME_WIDTH-1:0] interval_b_to_a_o,
  output dir_e                  direction_o,
  output dir_e                  reported_direction_o,
  output drdd_res_t             result_o
);

  // Compare width wide enough for both the time and the register values.
  localparam int unsigned ExtWidth = (TIME_WIDTH > CfgWidth) ? TIME_WIDTH : CfgWidth;

  // big > 8 * small, exact, for nonzero operands
  function automatic logic exceeds_eight(input logic [TIME_WIDTH-1:0] big,
                                         input logic [TIME_WIDTH-1:0] small_v);
    logic [TIME_WIDTH-1:0] dec;
    dec = big - TIME_WIDTH'(1);
    return (dec >> 3) >= small_v;
  endfunction

  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] stamp;
  logic [TIME_WIDTH-1:0] diff_a;
  logic [TIME_WIDTH-1:0] diff_b;
  logic [TIME_WIDTH-1:0] idle_time;

  assign now       = TIME_WIDTH'(ExtWidth'(now_tick_i));
  assign stamp     = (now <= last_pulse_time_i) ? last_pulse_time_i + TIME_WIDTH'(1) : now;
  assign diff_a    = stamp - pulse_time_b_i;
  assign diff_b    = stamp - pulse_time_a_i;
  assign idle_time = now - last_pulse_time_i;

  always_comb begin
    last_pulse_time_o    = last_pulse_time_i;
    pulse_time_a_o       = pulse_time_a_i;
    pulse_time_b_o       = pulse_time_b_i;
    interval_a_to_b_o    = interval_a_to_b_i;
    interval_b_to_a_o    = interval_b_to_a_i;
    direction_o          = direction_i;
    reported_direction_o = reported_direction_i;
    result_o.announce    = AnnNone;

    case (func_i)
      FuncPulseA: begin
        last_pulse_time_o = stamp;
        pulse_time_a_o    = stamp;
        // a zero stamp on the other sensor means it was never seen
        if (pulse_time_b_i != '0) begin
          if (ExtWidth'(diff_a) < ExtWidth'(check_window_i)) direction_o = DirForward;
          interval_b_to_a_o = diff_a;
        end
      end
      FuncPulseB: begin
        last_pulse_time_o = stamp;
        pulse_time_b_o    = stamp;
        if (pulse_time_a_i != '0) begin
          if (ExtWidth'(diff_b) < ExtWidth'(check_window_i)) direction_o = DirReverse;
          interval_a_to_b_o = diff_b;
        end
      end
      FuncCheck: begin
        if (reported_direction_i != direction_i) begin
          case (direction_i)
            DirForward: result_o.announce = AnnForward;
            DirReverse: result_o.announce = AnnReverse;
            default:    result_o.announce = AnnStopped;
          endcase
          reported_direction_o = direction_i;
        end
        if (now > last_pulse_time_i) begin
          if (ExtWidth'(idle_time) > ExtWidth'(stop_timeout_i)) begin
            direction_o       = DirStopped;
            interval_a_to_b_o = '0;
            interval_b_to_a_o = '0;
          end else if (interval_a_to_b_i != '0 && interval_b_to_a_i != '0) begin
            if (exceeds_eight(interval_b_to_a_i, interval_a_to_b_i)) begin
              direction_o = DirReverse;
            end else if (exceeds_eight(interval_a_to_b_i, interval_b_to_a_i)) begin
              direction_o = DirForward;
            end
          end
        end
      end
      default: ;
    endcase

    result_o.drum_state = direction_o;
  end

endmodule

/* rtl/core/drum_rotation_direction_detector_core.sv */
// Top level of the drum rotation direction detector: input stage, state, result stage.
// Each request is registered in the input stage, then its result in the result stage.
// Throughput: one request per cycle unless the result is stalled; the state update of the
//   evaluation stage is a single pass of subtract and compare logic between two registers.
// A stalled result holds at most one request in the input stage; further requests wait.
// Reset: asynchronous, active low; clears valids and state, loads register defaults.
module drum_rotation_direction_detector_core import drdd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]      cfg_data_i,
  // event stream in
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [TickWidth-1:0]     s_axis_tdata,   // [31:0] now_tick
  input  logic [1:0]               s_axis_tuser,   // [1:0] func
  // result stream out
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata    // [1:0] drum_state, [3:2] announce, zeros
);

  logic [CfgWidth-1:0] check_window_q;
  logic [CfgWidth-1:0] stop_timeout_q;

  logic                 in_valid_q;
  logic [1:0]           in_func_q;
  logic [TickWidth-1:0] in_tick_q;

  logic      out_valid_q;
  drdd_res_t out_res_q;

  logic [TIME_WIDTH-1:0] last_pulse_time_q, last_pulse_time_d;
  logic [TIME_WIDTH-1:0] pulse_time_a_q, pulse_time_a_d;
  logic [TIME_WIDTH-1:0] pulse_time_b_q, pulse_time_b_d;
  logic [TIME_WIDTH-1:0] interval_a_to_b_q, interval_a_to_b_d;
  logic [TIME_WIDTH-1:0] interval_b_to_a_q, interval_b_to_a_d;
  dir_e                  direction_q, direction_d;
  dir_e                  reported_direction_q, reported_direction_d;
  drdd_res_t             result;

  logic advance;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_window_q <= CheckWindowReset;
      stop_timeout_q <= StopTimeoutReset;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegCheckWindow: check_window_q <= cfg_data_i;
        RegStopTimeout: stop_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q <= s_axis_tuser;
      in_tick_q <= s_axis_tdata;
    end
  end

  drdd_eval #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_eval (
    .func_i               (in_func_q),
    .now_tick_i           (in_tick_q),
    .check_window_i       (check_window_q),
    .stop_timeout_i       (stop_timeout_q),
    .last_pulse_time_i    (last_pulse_time_q),
    .pulse_time_a_i       (pulse_time_a_q),
    .pulse_time_b_i       (pulse_time_b_q),
    .interval_a_to_b_i    (interval_a_to_b_q),
    .interval_b_to_a_i    (interval_b_to_a_q),
    .direction_i          (direction_q),
    .reported_direction_i (reported_direction_q),
    .last_pulse_time_o    (last_pulse_time_d),
    .pulse_time_a_o       (pulse_time_a_d),
    .pulse_time_b_o       (pulse_time_b_d),
    .interval_a_to_b_o    (interval_a_to_b_d),
    .interval_b_to_a_o    (interval_b_to_a_d),
    .direction_o          (direction_d),
    .reported_direction_o (reported_direction_d),
    .result_o             (result)
  );

  // Commit the state only when the result can move into the output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pulse_time_q    <= '0;
      pulse_time_a_q       <= '0;
      pulse_time_b_q       <= '0;
      interval_a_to_b_q    <= '0;
      interval_b_to_a_q    <= '0;
      direction_q          <= DirStopped;
      reported_direction_q <= DirStopped;
    end else if (advance) begin
      last_pulse_time_q    <= last_pulse_time_d;
      pulse_time_a_q       <= pulse_time_a_d;
      pulse_time_b_q       <= pulse_time_b_d;
      interval_a_to_b_q    <= interval_a_to_b_d;
      interval_b_to_a_q    <= interval_b_to_a_d;
      direction_q          <= direction_d;
      reported_direction_q <= reported_direction_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= result;
    end
  end

  // A request waiting in the input stage is never dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("held request lost from input stage");

  // Only a check may move the announced direction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && in_func_q == FuncCheck) |=> $stable(reported_direction_q))
    else $error("announced direction changed outside a check");

  // Pulses never announce anything.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_func_q != FuncCheck |=> out_res_q.announce == AnnNone)
    else $error("announcement on a non-check request");

  // The result follows the committed direction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_res_q.drum_state == direction_q)
    else $error("result direction differs from state");

endmodule

/* tb/sv/drum_rotation_direction_detector_core_tb.sv */
// Testbench of the drum rotation direction detector core: event stream, predictor, checker.
module drum_rotation_direction_detector_core_tb;
  import drdd_pkg::*;

  localparam logic [1:0]  FuncUnused    = 2'd3;
  localparam int unsigned WatchdogLimit = 5000;

  typedef enum logic [1:0] {
    SpinLead,
    SpinLag,
    SpinCheck
  } spin_step_e;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  reg_idx_e                 cfg_index_i   = RegCheckWindow;
  logic [CfgWidth-1:0]      cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [TickWidth-1:0]     s_axis_tdata  = '0;  // [31:0] now_tick
  logic [1:0]               s_axis_tuser  = '0;  // [1:0] func
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [7:0]               m_axis_tdata;        // [1:0] drum_state, [3:2] announce

  drum_rotation_direction_detector_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted detector state and its registers
  logic [31:0] window_cfg  = CheckWindowReset;
  logic [31:0] timeout_cfg = StopTimeoutReset;
  logic [31:0] stamp_last  = '0;
  logic [31:0] seen_a_at   = '0;
  logic [31:0] seen_b_at   = '0;
  logic [31:0] gap_a_to_b  = '0;
  logic [31:0] gap_b_to_a  = '0;
  dir_e        dir_now     = DirStopped;
  dir_e        dir_told    = DirStopped;

  drdd_res_t   expected_readings_q[$];

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned checks_seen  = 0;
  int unsigned announced    = 0;
  int unsigned stops_told   = 0;
  int unsigned cfg_writes   = 0;
  int unsigned errors       = 0;
  int unsigned idle_cycles  = 0;
  int unsigned sink_hold    = 0;
  bit          steady_flow  = 1'b0;

  // Stimulus generator state
  logic [31:0] drum_tick  = '0;
  logic [31:0] lag_ticks  = '0;
  bit          lead_a     = 1'b1;
  spin_step_e  spin_phase = SpinLead;

  function automatic bit over_eight_times(logic [31:0] big, logic [31:0] little);
    return {3'b000, big} > {little, 3'b000};
  endfunction

  task automatic step_drum_model(input logic [1:0] kind, input logic [31:0] tick,
                                 output drdd_res_t res);
    logic [31:0] gap;
    ann_e        said;
    said = AnnNone;
    // pulses get a strictly increasing stamp, wrapping past all ones to zero
    if (kind == FuncPulseA || kind == FuncPulseB) begin
      if (tick <= stamp_last) stamp_last = stamp_last + 32'd1;
      else stamp_last = tick;
    end
    case (kind)
      FuncPulseA: begin
        seen_a_at = stamp_last;
        if (seen_b_at != '0) begin
          gap = seen_a_at - seen_b_at;
          if (gap < window_cfg) dir_now = DirForward;
          gap_b_to_a = gap;
        end
      end
      FuncPulseB: begin
        seen_b_at = stamp_last;
        if (seen_a_at != '0) begin
          gap = seen_b_at - seen_a_at;
          if (gap < window_cfg) dir_now = DirReverse;
          gap_a_to_b = gap;
        end
      end
      FuncCheck: begin
        if (dir_told != dir_now) begin
          case (dir_now)
            DirForward: said = AnnForward;
            DirReverse: said = AnnReverse;
            default:    said = AnnStopped;
          endcase
          dir_told = dir_now;
        end
        if (tick > stamp_last) begin
          if (tick - stamp_last > timeout_cfg) begin
            dir_now    = DirStopped;
            gap_a_to_b = '0;
            gap_b_to_a = '0;
          end else if (gap_a_to_b != '0 && gap_b_to_a != '0) begin
            if (over_eight_times(gap_b_to_a, gap_a_to_b)) dir_now = DirReverse;
            else if (over_eight_times(gap_a_to_b, gap_b_to_a)) dir_now = DirForward;
          end
        end
      end
      default: ;
    endcase
    res.drum_state = dir_now;
    res.announce   = said;
  endtask

  // Register writes, result checks and prediction, in that order
  always @(posedge clk_i) begin
    drdd_res_t got;
    drdd_res_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegCheckWindow: window_cfg  = cfg_data_i;
          RegStopTimeout: timeout_cfg = cfg_data_i;
          default: ;
        endcase
        cfg_writes++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = drdd_res_t'(m_axis_tdata[3:0]);
        results_seen++;
        if (expected_readings_q.size() == 0) begin
          $display("%0t: result with no request pending: drum_state %0d announce %0d",
                   $time, got.drum_state, got.announce);
          errors++;
        end else begin
          want = expected_readings_q.pop_front();
          if (got.drum_state !== want.drum_state) begin
            $display("%0t: drum_state mismatch: expected %0d, actual %0d",
                     $time, want.drum_state, got.drum_state);
            errors++;
          end
          if (got.announce !== want.announce) begin
            $display("%0t: announce mismatch: expected %0d, actual %0d",
                     $time, want.announce, got.announce);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_drum_model(s_axis_tuser, s_axis_tdata, want);
        expected_readings_q.push_back(want);
        if (s_axis_tuser == FuncCheck) checks_seen++;
        if (want.announce != AnnNone) announced++;
        if (want.announce == AnnStopped) stops_told++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_readings_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Mostly short gaps, a few long ones; no gap while steady_flow is set
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result sink: alternate runs of ready with stalls
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold--;
    end else if (m_axis_tready) begin
      sink_hold = idle_len();
      if (sink_hold != 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else begin
        sink_hold = $urandom_range(0, 6);
      end
    end else begin
      m_axis_tready <= 1'b1;
      sink_hold = $urandom_range(0, 6);
    end
  end

  task automatic send_event(input logic [1:0] kind, input logic [31:0] tick);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tick;
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop the request and hold until every result is back
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [31:0] window, input logic [31:0] timeout);
    quiesce();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegCheckWindow;
    cfg_data_i  <= window;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= RegStopTimeout;
    cfg_data_i  <= timeout;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One step of a plausible rotation: lead pulse, lag pulse, then one or more checks
  task automatic emit_rotation_step();
    int unsigned r;
    case (spin_phase)
      SpinLead: begin
        if ($urandom_range(0, 5) == 0) lead_a = !lead_a;
        r = $urandom_range(0, 9);
        if (r < 4) lag_ticks = $urandom_range(0, 150);
        else if (r < 6) lag_ticks = window_cfg + $urandom_range(0, 2) - 32'd1;
        else lag_ticks = $urandom_range(0, 3000);
        if ($urandom_range(0, 3) == 0) drum_tick += $urandom_range(0, 20000);
        else drum_tick += $urandom_range(1, 4000);
        send_event(lead_a ? FuncPulseA : FuncPulseB, drum_tick);
        spin_phase = SpinLag;
      end
      SpinLag: begin
        drum_tick += lag_ticks;
        send_event(lead_a ? FuncPulseB : FuncPulseA, drum_tick);
        spin_phase = SpinCheck;
      end
      default: begin
        drum_tick += $urandom_range(0, 60);
        send_event(FuncCheck, drum_tick);
        if ($urandom_range(0, 2) != 0) spin_phase = SpinLead;
      end
    endcase
  endtask

  task automatic run_spinning_drum(input int unsigned count);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        emit_rotation_step();
      end else if (r < 88) begin
        // silence at or beyond the stop timeout
        if ($urandom_range(0, 3) == 0) drum_tick += timeout_cfg + $urandom;
        else drum_tick += timeout_cfg + $urandom_range(0, 2);
        send_event(FuncCheck, drum_tick);
      end else if (r < 95) begin
        send_event(2'($urandom_range(0, 3)), $urandom);
      end else begin
        drum_tick = 32'hFFFF_FFFF - $urandom_range(0, 40);
        send_event(2'($urandom_range(0, 2)), drum_tick);
      end
    end
  endtask

  task automatic test_directed_cases();
    send_event(FuncCheck,  32'd0);       // check at time zero: nothing to do
    send_event(FuncUnused, 32'd123);
    send_event(FuncPulseA, 32'd0);       // stamp bumped past zero
    send_event(FuncPulseB, 32'd50);      // B follows A inside the window
    send_event(FuncCheck,  32'd60);
    send_event(FuncPulseA, 32'd40);      // late tick, stamp advanced by one
    send_event(FuncCheck,  32'd51);      // not after last stamp: announce only
    send_event(FuncCheck,  32'd15051);   // exactly at the stop timeout
    send_event(FuncCheck,  32'd15052);   // one past: stopped
    send_event(FuncCheck,  32'd15053);
    send_event(FuncPulseA, 32'd20000);
    send_event(FuncPulseB, 32'd20100);   // interval equal to the window
    send_event(FuncPulseA, 32'd20900);   // ratio exactly eight
    send_event(FuncCheck,  32'd20901);
    send_event(FuncPulseA, 32'd20901);   // ratio just above eight
    send_event(FuncCheck,  32'd20902);
    send_event(FuncCheck,  32'd20903);
    send_event(FuncPulseB, 32'd27310);   // mirror ratio just above eight
    send_event(FuncCheck,  32'd27311);
    send_event(FuncCheck,  32'd27312);
    send_event(FuncPulseA, 32'hFFFF_FFFF);
    send_event(FuncPulseB, 32'd5);       // stamp wraps to zero
    send_event(FuncPulseA, 32'd3);       // B now reads as never seen
    send_event(FuncCheck,  32'hFFFF_FFFF);
    send_event(FuncCheck,  32'd0);
  endtask

  task automatic test_register_extremes();
    apply_setting(32'd0, 32'd0);
    run_spinning_drum(150);
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_spinning_drum(150);
  endtask

  task automatic test_random_settings();
    logic [31:0] window;
    logic [31:0] timeout;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin
          window  = $urandom_range(1, 400);
          timeout = $urandom_range(500, 30000);
        end
        1: begin
          window  = $urandom;
          timeout = $urandom;
        end
        2: begin
          window  = CheckWindowReset;
          timeout = StopTimeoutReset;
        end
        default: begin
          window  = $urandom_range(0, 20);
          timeout = $urandom_range(0, 50);
        end
      endcase
      apply_setting(window, timeout);
      steady_flow = (phase == 5);
      run_spinning_drum(210);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_register_extremes();
    test_random_settings();
    quiesce();
    repeat (4) @(posedge clk_i);
    if (expected_readings_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_readings_q.size());
      errors++;
    end
    $display("Ran %0d events (%0d checks) over %0d register writes;", items_sent, checks_seen,
             cfg_writes);
    $display("saw %0d announcements, %0d of them stops, and %0d mismatches.", announced,
             stops_told, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* drum_rotation_direction_detector_core.f */
rtl/core/drdd_pkg.sv
rtl/core/drdd_eval.sv
rtl/core/drum_rotation_direction_detector_core.sv
tb/sv/drum_rotation_direction_detector_core_tb.sv
